// File: hw/rtl/ktpa_pkg.sv
// shared types and constants for the kerned text pen-advance engine
package ktpa_pkg;

   localparam int GLYPH_COUNT_DEF = 96;
   localparam int PEN_BITS_DEF    = 16;
   localparam int CHAR_OFFSET     = 32;
   localparam int KERN_GAP        = 2;
   localparam int IDX_W           = 7;
   localparam int SPACE_W         = 6;
   localparam int CMD_DEPTH       = 4;
   localparam int RSP_DEPTH       = 2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_BEGIN  = 2'd1,
      OP_CHAR   = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_LOAD,
      CMD_BEGIN,
      CMD_SPACE,
      CMD_DRAW,
      CMD_FINISH
   } cmd_kind_type;

   typedef struct packed {
      op_type             opcode;
      logic [IDX_W-1:0]   table_prev;
      logic [IDX_W-1:0]   table_next;
      logic signed [7:0]  table_value;
      logic signed [15:0] start_x;
      logic signed [7:0]  char_code;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pen_x;
      logic [IDX_W-1:0]   glyph_index;
      logic               draw_glyph;
      logic               is_total;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [IDX_W-1:0]   tbl_prev;
      logic [IDX_W-1:0]   tbl_next;
      logic signed [7:0]  value;
      logic signed [15:0] start_x;
   } cmd_type;

endpackage

// File: hw/rtl/ktpa_fifo.sv
// small register-based queue
module ktpa_fifo
   import ktpa_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hw/rtl/ktpa_front.sv
// front end: takes request beats, maps codes to glyphs, tracks the previous glyph
module ktpa_front
   import ktpa_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_item,
   output logic    full,
   output logic    cmd_push,
   output cmd_type cmd_item,
   input  logic    cmd_full
);

   localparam int GIDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

   logic [GIDX_W-1:0]  prev_ff, prev_in;
   logic               take;
   logic signed [8:0]  code_diff;
   logic [GIDX_W-1:0]  glyph;
   logic               load_ok;

   assign full = cmd_full;
   assign take = push && !cmd_full;

   // code minus offset, clamped into the glyph range
   always_comb begin
      code_diff = 9'(req_item.char_code) - 9'sd32;
      if (code_diff < 0) begin
         glyph = '0;
      end else if (int'(code_diff) > GLYPH_COUNT - 1) begin
         glyph = GIDX_W'(GLYPH_COUNT - 1);
      end else begin
         glyph = code_diff[GIDX_W-1:0];
      end
   end

   assign load_ok = (int'(req_item.table_prev) < GLYPH_COUNT)
                 && (int'(req_item.table_next) < GLYPH_COUNT);

   always_comb begin
      prev_in           = prev_ff;
      cmd_push          = 1'b0;
      cmd_item.kind     = CMD_LOAD;
      cmd_item.tbl_prev = IDX_W'(prev_ff);
      cmd_item.tbl_next = IDX_W'(glyph);
      cmd_item.value    = req_item.table_value;
      cmd_item.start_x  = req_item.start_x;
      case (req_item.opcode)
         OP_LOAD: begin
            cmd_item.tbl_prev = req_item.table_prev;
            cmd_item.tbl_next = req_item.table_next;
            cmd_push          = take && load_ok;
         end
         OP_BEGIN: begin
            cmd_item.kind = CMD_BEGIN;
            cmd_push      = take;
            if (take) begin
               prev_in = '0;
            end
         end
         OP_CHAR: begin
            cmd_push = take;
            if (glyph == '0) begin
               cmd_item.kind = CMD_SPACE;
            end else begin
               cmd_item.kind = CMD_DRAW;
               if (take) begin
                  prev_in = glyph;
               end
            end
         end
         default: begin
            cmd_item.kind = CMD_FINISH;
            cmd_push      = take;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

// File: hw/rtl/ktpa_back.sv
// back end: pair table, pen accumulator and result formation
module ktpa_back
   import ktpa_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
   parameter int PEN_BITS    = PEN_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SPACE_W-1:0] space_width,
   input  logic               cmd_empty,
   input  cmd_type            cmd_item,
   output logic               cmd_pop,
   output logic               rsp_push,
   output rsp_type            rsp_data,
   input  logic               rsp_full
);

   localparam int GIDX_W    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int ADDR_W    = 2 * GIDX_W;
   localparam int TBL_DEPTH = 1 << ADDR_W;
   localparam int ADD_W     = 10;
   localparam int WIDE_W    = ((PEN_BITS > 16) ? PEN_BITS : 16) + 2;
   localparam logic signed [WIDE_W-1:0] PEN_MAX =
      WIDE_W'((64'sd1 <<< (PEN_BITS - 1)) - 64'sd1);
   localparam logic signed [WIDE_W-1:0] PEN_MIN = -PEN_MAX - WIDE_W'(1);

   logic [7:0]                tbl_mem [TBL_DEPTH];
   logic [7:0]                rdata_ff;
   logic                      s1_valid_ff, s1_valid_in;
   cmd_type                   s1_cmd_ff;
   logic signed [PEN_BITS-1:0] pen_ff, pen_in;

   logic [ADDR_W-1:0]         addr;
   logic                      needs_out, advance;
   logic signed [7:0]         tdata;
   logic signed [ADD_W-1:0]   addend;
   logic signed [WIDE_W-1:0]  wide_val;
   logic signed [WIDE_W-1:0]  pen_ext;

   assign addr = {cmd_item.tbl_prev[GIDX_W-1:0], cmd_item.tbl_next[GIDX_W-1:0]};

   assign needs_out = (s1_cmd_ff.kind == CMD_SPACE) || (s1_cmd_ff.kind == CMD_DRAW)
                   || (s1_cmd_ff.kind == CMD_FINISH);
   assign advance   = s1_valid_ff && (!needs_out || !rsp_full);
   assign cmd_pop   = !cmd_empty && (!s1_valid_ff || advance);
   assign rsp_push  = s1_valid_ff && needs_out && !rsp_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (cmd_pop) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // single port: loads write, everything else reads
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         if (cmd_item.kind == CMD_LOAD) begin
            tbl_mem[addr] <= cmd_item.value;
         end else begin
            rdata_ff <= tbl_mem[addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_cmd_ff <= cmd_item;
      end
   end

   // pen update with saturation
   always_comb begin
      tdata  = $signed(rdata_ff);
      addend = '0;
      case (s1_cmd_ff.kind)
         CMD_SPACE:  addend = $signed({{(ADD_W - SPACE_W){1'b0}}, space_width});
         CMD_DRAW:   addend = ADD_W'(tdata) + ADD_W'(KERN_GAP);
         CMD_FINISH: addend = ADD_W'(tdata);
         default:    addend = '0;
      endcase
      if (s1_cmd_ff.kind == CMD_BEGIN) begin
         wide_val = WIDE_W'(s1_cmd_ff.start_x);
      end else begin
         wide_val = WIDE_W'(pen_ff) + WIDE_W'(addend);
      end
      if (wide_val > PEN_MAX) begin
         pen_in = PEN_MAX[PEN_BITS-1:0];
      end else if (wide_val < PEN_MIN) begin
         pen_in = PEN_MIN[PEN_BITS-1:0];
      end else begin
         pen_in = wide_val[PEN_BITS-1:0];
      end
      pen_ext = WIDE_W'(pen_in);
   end

   always_comb begin
      rsp_data.pen_x       = pen_ext[15:0];
      rsp_data.glyph_index = s1_cmd_ff.tbl_next;
      rsp_data.draw_glyph  = (s1_cmd_ff.kind == CMD_DRAW);
      rsp_data.is_total    = (s1_cmd_ff.kind == CMD_FINISH);
      if (s1_cmd_ff.kind == CMD_SPACE) begin
         rsp_data.glyph_index = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pen_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance && (s1_cmd_ff.kind != CMD_LOAD)) begin
            pen_ff <= pen_in;
         end
      end
   end

endmodule

// File: hw/rtl/kerned_text_pen_advance.sv
// top level of the kerned text pen-advance engine
//
//  channel   ports                        direction  beat
//  request   push / full / req_item       in         one load, begin, character or finish
//  result    empty / pop / rsp_item       out        one pen position or total width
//  csr       csr_wr_en / csr_wdata        in         space width, no read-back
//
// one item per cycle sustained while the result queue has room, set by the single
// pair-table port and the pen add-and-saturate loop in the back end
// a result goes through the command queue and back-end stage register to the result queue
// reset clears the queues, pen, previous glyph and space width;
// the pair table is not cleared and must be loaded before use
// a full result queue stalls the back end; the front keeps taking beats until
// the command queue fills
module kerned_text_pen_advance
   import ktpa_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
   parameter int PEN_BITS    = PEN_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  req_type            req_item,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_item,
   input  logic               csr_wr_en,
   input  logic [SPACE_W-1:0] csr_wdata
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   // space width register
   logic [SPACE_W-1:0] space_width_ff;

   // front to command queue
   logic       cmd_push, cmd_full;
   cmd_type    cmd_wr_item;

   // command queue to back end
   logic             cmd_empty, cmd_pop;
   logic [CMD_W-1:0] cmd_rd_bits;

   // back end to result queue
   logic             rsp_push, rsp_full;
   rsp_type          rsp_wr_item;
   logic [RSP_W-1:0] rsp_rd_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         space_width_ff <= '0;
      end else if (csr_wr_en) begin
         space_width_ff <= csr_wdata;
      end
   end

   // classify beats and pair each glyph with its predecessor
   ktpa_front #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .full     (full),
      .cmd_push (cmd_push),
      .cmd_item (cmd_wr_item),
      .cmd_full (cmd_full)
   );

   // decouples front from back
   ktpa_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr_item),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd_bits),
      .empty   (cmd_empty)
   );

   // table lookup and pen accumulation
   ktpa_back #(
      .GLYPH_COUNT(GLYPH_COUNT),
      .PEN_BITS   (PEN_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .space_width (space_width_ff),
      .cmd_empty   (cmd_empty),
      .cmd_item    (cmd_type'(cmd_rd_bits)),
      .cmd_pop     (cmd_pop),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_wr_item),
      .rsp_full    (rsp_full)
   );

   // result queue, head drives the result ports
   ktpa_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wr_item),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_rd_bits),
      .empty   (empty)
   );

   assign rsp_item = rsp_type'(rsp_rd_bits);

endmodule

// File: hw/rtl/ktpa_checker.sv
// port-level checks for the kerned text pen-advance engine, bound to the top level
module ktpa_checker
   import ktpa_pkg::*;
#(
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input rsp_type rsp_item
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a total never marks a drawn glyph
   a_total_no_draw: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.is_total) |-> !rsp_item.draw_glyph)
      else $error("total result flagged as drawn");

   // drawn glyphs are never the space glyph, space results carry glyph zero
   a_draw_glyph: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.is_total) |-> (rsp_item.draw_glyph == (rsp_item.glyph_index != '0)))
      else $error("draw flag disagrees with glyph index");

   // glyph index stays in range
   a_glyph_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (int'(rsp_item.glyph_index) < GLYPH_COUNT))
      else $error("glyph index out of range");

endmodule

bind kerned_text_pen_advance ktpa_checker #(
   .GLYPH_COUNT(GLYPH_COUNT)
) u_ktpa_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .rsp_item (rsp_item)
);

// File: tb/sv/pen_advance_monitor.sv
`timescale 1ns / 1ps
// beat monitor for the kerned text pen-advance engine: predicts each result and compares it
module pen_advance_monitor
   import ktpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  req_type            req_item,
   input  logic               empty,
   input  logic               pop,
   input  rsp_type            rsp_item,
   input  logic               csr_wr_en,
   input  logic [SPACE_W-1:0] csr_wdata,
   output int                 mismatch_count,
   output int                 waiting_count,
   output int                 compared_count
);

   localparam int PEN_MAX = (1 << (PEN_BITS_DEF - 1)) - 1;
   localparam int PEN_MIN = -PEN_MAX - 1;

   logic signed [7:0]  pair_advance [GLYPH_COUNT_DEF][GLYPH_COUNT_DEF];
   int                 pen_now;
   int                 last_glyph;
   logic [SPACE_W-1:0] space_width;
   rsp_type            expected_pens [$];

   function automatic int clamp_pen(input int v);
      if (v > PEN_MAX) return PEN_MAX;
      if (v < PEN_MIN) return PEN_MIN;
      return v;
   endfunction

   function automatic int glyph_of_code(input logic signed [7:0] code);
      int g;
      g = int'(code) - CHAR_OFFSET;
      if (g < 0) g = 0;
      if (g > GLYPH_COUNT_DEF - 1) g = GLYPH_COUNT_DEF - 1;
      return g;
   endfunction

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got_v, want_v);
      mismatch_count++;
   endtask

   task automatic predict_pen_step(input req_type beat);
      rsp_type want;
      int      g;
      want = '0;
      case (beat.opcode)
         OP_LOAD: begin
            // indices outside the glyph range leave the table alone
            if (beat.table_prev < GLYPH_COUNT_DEF && beat.table_next < GLYPH_COUNT_DEF)
               pair_advance[beat.table_prev][beat.table_next] = beat.table_value;
         end
         OP_BEGIN: begin
            pen_now    = clamp_pen(int'(beat.start_x));
            last_glyph = 0;
         end
         default: begin
            g = glyph_of_code(beat.char_code);
            if (beat.opcode == OP_FINISH) begin
               pen_now        = clamp_pen(pen_now + int'(pair_advance[last_glyph][g]));
               want.is_total  = 1'b1;
            end else if (g == 0) begin
               pen_now = clamp_pen(pen_now + int'(space_width));
            end else begin
               pen_now = clamp_pen(pen_now + int'(pair_advance[last_glyph][g]) + KERN_GAP);
               last_glyph      = g;
               want.draw_glyph = 1'b1;
            end
            want.pen_x       = pen_now[15:0];
            want.glyph_index = g[IDX_W-1:0];
            expected_pens.push_back(want);
         end
      endcase
   endtask

   task automatic check_pen_beat(input rsp_type got);
      rsp_type want;
      compared_count++;
      if (expected_pens.size() == 0) begin
         report_mismatch("result beat with nothing pending, pen_x", int'(got.pen_x), 0);
         return;
      end
      want = expected_pens.pop_front();
      if (got.pen_x !== want.pen_x)
         report_mismatch("pen_x", int'(got.pen_x), int'(want.pen_x));
      if (got.glyph_index !== want.glyph_index)
         report_mismatch("glyph_index", int'(got.glyph_index), int'(want.glyph_index));
      if (got.draw_glyph !== want.draw_glyph)
         report_mismatch("draw_glyph", int'(got.draw_glyph), int'(want.draw_glyph));
      if (got.is_total !== want.is_total)
         report_mismatch("is_total", int'(got.is_total), int'(want.is_total));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pens.delete();
         pen_now     = 0;
         last_glyph  = 0;
         space_width = '0;
      end else begin
         if (csr_wr_en) space_width = csr_wdata;
         if (push && !full) predict_pen_step(req_item);
         if (pop && !empty) check_pen_beat(rsp_item);
      end
      waiting_count <= expected_pens.size();
   end

endmodule

// File: tb/sv/tb_kerned_text_pen_advance.sv
`timescale 1ns / 1ps
// testbench top for the kerned text pen-advance engine: stimulus, handshakes and verdict
module tb_kerned_text_pen_advance;
   import ktpa_pkg::*;

   localparam int RANDOM_BEATS  = 1550;
   localparam int PHASES        = 6;
   localparam int IDLE_PCT      = 19;
   // the path through to the result queue plus a command queue's worth of beats
   localparam int SETTLE_CYCLES = 8;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               push      = 1'b0;
   req_type            req_item  = '0;
   logic               full;
   logic               empty;
   logic               pop       = 1'b0;
   rsp_type            rsp_item;
   logic               csr_wr_en = 1'b0;
   logic [SPACE_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int results_checked;

   // no idling on either side while set
   bit steady = 1'b0;
   int beats_sent  = 0;
   int widths_used = 0;
   // previous glyph as the block will see it, so that no unwritten pair is read
   int glyph_in_hand = 0;
   bit pair_loaded [GLYPH_COUNT_DEF][GLYPH_COUNT_DEF];
   // small working alphabet so pairs repeat and strings look like text
   logic [7:0] alphabet [10];

   always #10 clock = ~clock;

   kerned_text_pen_advance dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_item  (req_item),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_wdata (csr_wdata)
   );

   pen_advance_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_item       (req_item),
      .empty          (empty),
      .pop            (pop),
      .rsp_item       (rsp_item),
      .csr_wr_en      (csr_wr_en),
      .csr_wdata      (csr_wdata),
      .mismatch_count (fail_count),
      .waiting_count  (pending),
      .compared_count (results_checked)
   );

   // result side: pop held low through reset, random stalls otherwise unless steady is set
   always @(posedge clock)
      pop <= !reset && (steady || $urandom_range(0, 99) >= IDLE_PCT);

   // random filler in every field, opcode set by the caller
   function automatic req_type noise_beat(input op_type op);
      logic [63:0] raw;
      req_type     b;
      raw      = {$urandom, $urandom};
      b        = raw[$bits(req_type)-1:0];
      b.opcode = op;
      return b;
   endfunction

   function automatic logic [7:0] pick_code();
      if ($urandom_range(0, 99) < 70) return alphabet[$urandom_range(0, 9)];
      return 8'($urandom);
   endfunction

   // starts near either rail now and then so the pen saturates
   function automatic logic [15:0] pick_start();
      case ($urandom_range(0, 3))
         0:       return 16'h7fff - 16'($urandom_range(0, 400));
         1:       return 16'h8000 + 16'($urandom_range(0, 400));
         default: return 16'($urandom);
      endcase
   endfunction

   // one request beat, with random idle cycles ahead of it
   task automatic send_item(input req_type beat);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= beat;
      @(posedge clock);
      while (full) @(posedge clock);
      // dropped loads are not counted as work
      if (beat.opcode != OP_LOAD ||
          (beat.table_prev < GLYPH_COUNT_DEF && beat.table_next < GLYPH_COUNT_DEF))
         beats_sent++;
   endtask

   task automatic send_load(input int p, input int n, input logic signed [7:0] v);
      req_type b;
      b             = noise_beat(OP_LOAD);
      b.table_prev  = p[IDX_W-1:0];
      b.table_next  = n[IDX_W-1:0];
      b.table_value = v;
      if (p < GLYPH_COUNT_DEF && n < GLYPH_COUNT_DEF) pair_loaded[p][n] = 1'b1;
      send_item(b);
   endtask

   task automatic ensure_pair(input int p, input int n);
      if (!pair_loaded[p][n]) send_load(p, n, 8'($urandom));
   endtask

   task automatic send_begin(input logic signed [15:0] x);
      req_type b;
      b             = noise_beat(OP_BEGIN);
      b.start_x     = x;
      glyph_in_hand = 0;
      send_item(b);
   endtask

   task automatic send_text(input op_type op, input logic signed [7:0] code);
      req_type b;
      int      g;
      g = int'(code) - CHAR_OFFSET;
      if (g < 0) g = 0;
      if (g > GLYPH_COUNT_DEF - 1) g = GLYPH_COUNT_DEF - 1;
      // a space on a character beat uses no pair entry, a finish always does
      if (op == OP_FINISH || g != 0) ensure_pair(glyph_in_hand, g);
      b           = noise_beat(op);
      b.char_code = code;
      if (op == OP_CHAR && g != 0) glyph_in_hand = g;
      send_item(b);
   endtask

   task automatic send_random_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         send_begin(pick_start());
      else if (r < 20)
         send_text(OP_FINISH, pick_code());
      else if (r < 27)
         // indices may fall outside the glyph range
         send_load($urandom_range(0, 127), $urandom_range(0, 127), 8'($urandom));
      else
         send_text(OP_CHAR, pick_code());
   endtask

   // hold the sender until every result has been taken, then let loads settle
   task automatic drain_block();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_space(input logic [SPACE_W-1:0] w);
      csr_wr_en <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      widths_used++;
   endtask

   initial begin
      int phase_goal;
      bit held_back;
      held_back   = 1'b0;
      alphabet[0] = 8'd32;
      for (int i = 1; i < 10; i++) alphabet[i] = 8'($urandom_range(33, 127));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_space(6'd5);

      // loads outside the glyph range are dropped
      send_load(127, 127, -8'sd1);
      send_load(96, 3, 8'sd50);
      // characters before any begin carry on from the reset pen
      send_load(0, 33, 8'sd10);
      send_text(OP_CHAR, 8'sd65);
      send_text(OP_CHAR, 8'sd32);
      // negative code clamps to the space glyph
      send_text(OP_CHAR, 8'sh80);
      // highest code lands on the last glyph
      send_text(OP_CHAR, 8'sd127);
      send_text(OP_FINISH, 8'sd33);
      // pen driven into the upper rail
      send_load(0, 95, 8'sd127);
      send_load(95, 95, 8'sd127);
      send_begin(16'sh7fff);
      send_text(OP_CHAR, 8'sd127);
      send_text(OP_CHAR, 8'sd127);
      send_text(OP_FINISH, 8'sd127);
      // and into the lower rail
      send_load(0, 1, 8'sh80);
      send_load(1, 1, 8'sh80);
      send_begin(16'sh8000);
      send_text(OP_CHAR, 8'sd33);
      send_text(OP_CHAR, 8'sd33);
      send_text(OP_FINISH, 8'sd0);
      // finish right after a begin reads the pair from glyph zero
      send_begin(16'sd0);
      send_text(OP_FINISH, 8'sd31);
      drain_block();

      // random phases, space width changed only while the block is quiet
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            write_space(6'd63);
         else if (phase == 1)
            write_space(6'd0);
         else
            write_space(6'($urandom));
         steady     <= (phase == 3);
         phase_goal  = beats_sent + RANDOM_BEATS / PHASES;
         while (beats_sent < phase_goal) begin
            send_random_beat();
            if (phase == 2 && !held_back &&
                beats_sent >= phase_goal - RANDOM_BEATS / (2 * PHASES)) begin
               held_back = 1'b1;
               drain_block();
            end
         end
         drain_block();
      end

      $display("covered %0d request beats under %0d space widths, rails and clamps included",
               beats_sent, widths_used);
      $display("compared %0d result beats against the predicted pen", results_checked);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
